FILE: hw/rtl/sacl_pkg.sv
// Shared types, constants and helpers for the set-associative cache level.
package sacl_pkg;

    localparam int unsigned WAYS_DEF        = 4;
    localparam int unsigned SET_COUNT_DEF   = 64;
    localparam int unsigned LINE_OFS_DEF    = 6;
    localparam int unsigned ADDR_W          = 32;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned COUNT_W         = 16;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_FILL   = 2'd1,
        KIND_INVAL  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        POL_LRU  = 2'd0,
        POL_FIFO = 2'd1,
        POL_LFU  = 2'd2,
        POL_LFU3 = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_CLEAR = 2'd2
    } back_state_t;

    // Number of index bits: smallest b with 2^b >= sets.
    function automatic int unsigned idx_width(input int unsigned sets);
        int unsigned b;
        b = 0;
        while (b < 31 && (32'd1 << b) < sets)
            b++;
        return b;
    endfunction

    function automatic int unsigned clog2_min1(input int unsigned n);
        int unsigned b;
        b = 1;
        while ((32'd1 << b) < n)
            b++;
        return b;
    endfunction

endpackage

FILE: hw/rtl/sacl_ram.sv
// Generic single-port RAM with registered read.
module sacl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [sacl_pkg::clog2_min1(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]                 wr_data,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= wr_data;
        rd_data <= mem[addr];
    end

endmodule

FILE: hw/rtl/sacl_front.sv
// Front end: accepts items, decodes set and tag, and queues them for the back end.
module sacl_front #(
    parameter int unsigned SET_COUNT   = sacl_pkg::SET_COUNT_DEF,
    parameter int unsigned LINE_OFS    = sacl_pkg::LINE_OFS_DEF,
    parameter int unsigned SET_W       = sacl_pkg::clog2_min1(SET_COUNT),
    parameter int unsigned TAG_W       = sacl_pkg::ADDR_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_kind,
    input  logic [31:0]          in_address,
    input  logic                 in_write,
    output logic                 in_stall,
    output logic                 q_valid,
    output logic [1:0]           q_kind,
    output logic [SET_W-1:0]     q_set,
    output logic [TAG_W-1:0]     q_tag,
    output logic                 q_write,
    input  logic                 q_pop
);

    localparam int unsigned IDX_W = sacl_pkg::idx_width(SET_COUNT);
    localparam int unsigned SH    = LINE_OFS + IDX_W;
    localparam int unsigned QD    = 2;

    logic [1:0]       kind_reg  [QD];
    logic [SET_W-1:0] set_reg   [QD];
    logic [TAG_W-1:0] tag_reg   [QD];
    logic             write_reg [QD];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       cnt_reg;
    logic             push;
    logic [31:0]      line_num;
    logic [SET_W-1:0] set_dec;
    logic [TAG_W-1:0] tag_dec;

    assign line_num = in_address >> LINE_OFS;
    assign set_dec  = SET_W'(line_num % SET_COUNT);
    assign tag_dec  = (SH >= 32) ? '0 : TAG_W'(in_address >> SH);

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_kind   = kind_reg[rptr_reg];
    assign q_set    = set_reg[rptr_reg];
    assign q_tag    = tag_reg[rptr_reg];
    assign q_write  = write_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_reg[wptr_reg]  <= in_kind;
            set_reg[wptr_reg]   <= set_dec;
            tag_reg[wptr_reg]   <= tag_dec;
            write_reg[wptr_reg] <= in_write;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (q_pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("push lost");

endmodule

FILE: hw/rtl/sacl_back.sv
// Back end: reads one set, resolves the item, writes the set back and emits the result.
module sacl_back #(
    parameter int unsigned WAYS        = sacl_pkg::WAYS_DEF,
    parameter int unsigned SET_COUNT   = sacl_pkg::SET_COUNT_DEF,
    parameter int unsigned LINE_OFS    = sacl_pkg::LINE_OFS_DEF,
    parameter int unsigned SET_W       = sacl_pkg::clog2_min1(SET_COUNT),
    parameter int unsigned TAG_W       = sacl_pkg::ADDR_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       policy,
    input  logic             q_valid,
    input  logic [1:0]       q_kind,
    input  logic [SET_W-1:0] q_set,
    input  logic [TAG_W-1:0] q_tag,
    input  logic             q_write,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             hit,
    output logic             evicted,
    output logic [31:0]      victim_address,
    output logic             victim_dirty,
    output logic             dropped_dirty
);

    localparam int unsigned IDX_W = sacl_pkg::idx_width(SET_COUNT);
    localparam int unsigned SH    = LINE_OFS + IDX_W;
    localparam int unsigned TW    = sacl_pkg::TIME_W;
    localparam int unsigned CW    = sacl_pkg::COUNT_W;
    // entry: valid, dirty, tag, last use, fill time, use count
    localparam int unsigned ENT_W = 2 + TAG_W + TW + TW + CW;
    localparam int unsigned WAY_W = sacl_pkg::clog2_min1(WAYS);

    sacl_pkg::back_state_t state_reg, state_next;

    logic [SET_W-1:0] clr_reg;
    logic [SET_W-1:0] ram_addr;
    logic [TW-1:0]    clock_reg, clock_next;

    logic [ENT_W-1:0] rd_data [WAYS];
    logic [ENT_W-1:0] wr_data;
    logic [WAYS-1:0]  wr_en;

    logic [1:0]       kind_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             write_reg;

    logic             ov_reg, hit_reg, ev_reg, vd_reg, dd_reg;
    logic [31:0]      va_reg;

    logic [TAG_W-1:0] e_tag  [WAYS];
    logic [TW-1:0]    e_lu   [WAYS];
    logic [TW-1:0]    e_fill [WAYS];
    logic [CW-1:0]    e_cnt  [WAYS];

    logic             match_found;
    logic [WAY_W-1:0] match_way;
    logic [WAY_W-1:0] victim_way;
    logic [TW-1:0]    best;
    logic             have_inv;
    logic [TW-1:0]    key;
    logic [63:0]      va_wide;
    logic             take;
    logic [WAYS-1:0]  vset, dset;

    assign ram_addr = (state_reg == sacl_pkg::ST_CLEAR) ? clr_reg :
                      (state_reg == sacl_pkg::ST_IDLE)  ? q_set : set_reg;

    for (genvar w = 0; w < WAYS; w++)
    begin : g_way
        sacl_ram #(.WIDTH(ENT_W), .DEPTH(SET_COUNT)) u_ram (
            .clk     (clk),
            .wr_en   (wr_en[w]),
            .addr    (ram_addr),
            .wr_data (wr_data),
            .rd_data (rd_data[w])
        );
        assign vset[w]   = rd_data[w][ENT_W-1];
        assign dset[w]   = rd_data[w][ENT_W-2];
        assign e_tag[w]  = rd_data[w][ENT_W-3 -: TAG_W];
        assign e_lu[w]   = rd_data[w][TW+TW+CW-1 -: TW];
        assign e_fill[w] = rd_data[w][TW+CW-1 -: TW];
        assign e_cnt[w]  = rd_data[w][CW-1:0];
    end

    assign take = (state_reg == sacl_pkg::ST_IDLE) && q_valid && !(ov_reg && out_stall);
    assign q_pop = take;

    // Way search: lowest matching way; victim is lowest invalid way, else smallest key.
    always_comb
    begin
        match_found = 1'b0;
        match_way   = '0;
        victim_way  = '0;
        best        = '0;
        have_inv    = 1'b0;
        key         = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vset[w] && e_tag[w] == tag_reg)
            begin
                match_found = 1'b1;
                match_way   = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            case (policy)
                sacl_pkg::POL_LRU:  key = e_lu[w];
                sacl_pkg::POL_FIFO: key = e_fill[w];
                default:            key = TW'(e_cnt[w]);
            endcase
            if (!have_inv)
            begin
                if (!vset[w])
                begin
                    have_inv   = 1'b1;
                    victim_way = WAY_W'(w);
                end
                else if (w == 0 || key < best)
                begin
                    best       = key;
                    victim_way = WAY_W'(w);
                end
            end
        end
        va_wide = (64'(e_tag[victim_way]) << SH) | (64'(set_reg) << LINE_OFS);
    end

    always_comb
    begin
        state_next = state_reg;
        wr_en      = '0;
        wr_data    = rd_data[match_way];
        clock_next = clock_reg;
        unique case (state_reg)
            sacl_pkg::ST_CLEAR:
            begin
                wr_en   = '1;
                wr_data = '0;
                if (clr_reg == SET_W'(SET_COUNT - 1))
                    state_next = sacl_pkg::ST_IDLE;
            end
            sacl_pkg::ST_IDLE:
            begin
                if (take)
                    state_next = sacl_pkg::ST_READ;
            end
            sacl_pkg::ST_READ:
            begin
                state_next = sacl_pkg::ST_IDLE;
                if (kind_reg == sacl_pkg::KIND_LOOKUP)
                begin
                    if (clock_reg != '1)
                        clock_next = clock_reg + 1'b1;
                    if (match_found)
                    begin
                        wr_en[match_way] = 1'b1;
                        wr_data = {1'b1, dset[match_way] | write_reg,
                                   e_tag[match_way], clock_next, e_fill[match_way],
                                   (e_cnt[match_way] == '1) ? e_cnt[match_way]
                                                            : e_cnt[match_way] + 1'b1};
                    end
                end
                else if (kind_reg == sacl_pkg::KIND_FILL)
                begin
                    wr_en[victim_way] = 1'b1;
                    wr_data = {1'b1, write_reg, tag_reg, clock_reg, clock_reg, CW'(1)};
                end
                else if (kind_reg == sacl_pkg::KIND_INVAL)
                begin
                    if (match_found)
                    begin
                        wr_en[match_way] = 1'b1;
                        wr_data = {1'b0, rd_data[match_way][ENT_W-2:0]};
                    end
                end
            end
            default:
                state_next = sacl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= q_kind;
            set_reg   <= q_set;
            tag_reg   <= q_tag;
            write_reg <= q_write;
        end
        if (state_reg == sacl_pkg::ST_READ)
        begin
            hit_reg <= 1'b0;
            ev_reg  <= 1'b0;
            va_reg  <= '0;
            vd_reg  <= 1'b0;
            dd_reg  <= 1'b0;
            case (kind_reg)
                sacl_pkg::KIND_LOOKUP: hit_reg <= match_found;
                sacl_pkg::KIND_FILL:
                begin
                    if (vset[victim_way])
                    begin
                        ev_reg <= 1'b1;
                        va_reg <= va_wide[31:0];
                        vd_reg <= dset[victim_way];
                    end
                end
                sacl_pkg::KIND_INVAL: dd_reg <= match_found && dset[match_way];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sacl_pkg::ST_CLEAR;
            clr_reg   <= '0;
            clock_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clock_reg <= clock_next;
            if (state_reg == sacl_pkg::ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == sacl_pkg::ST_READ)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid      = ov_reg;
    assign hit            = hit_reg;
    assign evicted        = ev_reg;
    assign victim_address = va_reg;
    assign victim_dirty   = vd_reg;
    assign dropped_dirty  = dd_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sacl_pkg::ST_READ) |-> !(ov_reg && out_stall))
        else $error("result overwritten while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sacl_pkg::ST_CLEAR) |-> $onehot0(wr_en))
        else $error("multiple ways written");
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> state_reg == sacl_pkg::ST_READ)
        else $error("accepted item not processed");

endmodule

FILE: hw/rtl/set_assoc_cache_level_unit.sv
// Top level of the set-associative cache level tag store.
// Usage:
//   Input channel (in_valid/in_stall) carries kind, address and write. An item
//   is taken when in_valid is high and in_stall is low; a two-entry queue sits
//   between the decode front end and the set update back end.
//   Result channel (out_valid/out_stall) returns one item per input item, in
//   order: hit, evicted, victim_address, victim_dirty, dropped_dirty.
//   Config channel (cfg_valid/cfg_ready) writes replace_policy; write only
//   while the block is idle.
// Sequence: the set RAM read is issued while the back end is in IDLE and the
//   compare and write back happen in READ, so the back end takes no new item
//   until the last one is written back; the result is registered into out_valid.
// Reset: the lookup clock and the policy are cleared at once; valid and dirty
//   flags live in the set RAMs, which the back end zeroes in a clearing pass
//   over all SET_COUNT sets (64 by default). Items queue meanwhile.
// Stall: while out_stall holds a result, the back end waits and the queue
//   fills; in_stall rises when both queue entries are occupied.
module set_assoc_cache_level_unit #(
    parameter int unsigned WAYS        = sacl_pkg::WAYS_DEF,
    parameter int unsigned SET_COUNT   = sacl_pkg::SET_COUNT_DEF,
    parameter int unsigned LINE_OFS    = sacl_pkg::LINE_OFS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic        write,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic        evicted,
    output logic [31:0] victim_address,
    output logic        victim_dirty,
    output logic        dropped_dirty,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  replace_policy
);

    localparam int unsigned SET_W = sacl_pkg::clog2_min1(SET_COUNT);
    localparam int unsigned IDX_W = sacl_pkg::idx_width(SET_COUNT);
    localparam int unsigned TAG_W = (LINE_OFS + IDX_W >= 32) ? 1
                                    : 32 - LINE_OFS - IDX_W;

    logic [1:0]       policy_reg;
    logic             q_valid, q_write, q_pop;
    logic [1:0]       q_kind;
    logic [SET_W-1:0] q_set;
    logic [TAG_W-1:0] q_tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= sacl_pkg::POL_LRU;
        else if (cfg_valid)
            policy_reg <= replace_policy;
    end

    sacl_front #(
        .SET_COUNT(SET_COUNT), .LINE_OFS(LINE_OFS), .SET_W(SET_W), .TAG_W(TAG_W)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_kind(kind), .in_address(address), .in_write(write),
        .in_stall(in_stall),
        .q_valid(q_valid), .q_kind(q_kind), .q_set(q_set), .q_tag(q_tag),
        .q_write(q_write), .q_pop(q_pop)
    );

    sacl_back #(
        .WAYS(WAYS), .SET_COUNT(SET_COUNT), .LINE_OFS(LINE_OFS),
        .SET_W(SET_W), .TAG_W(TAG_W)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .policy(policy_reg),
        .q_valid(q_valid), .q_kind(q_kind), .q_set(q_set), .q_tag(q_tag),
        .q_write(q_write), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .evicted(evicted), .victim_address(victim_address),
        .victim_dirty(victim_dirty), .dropped_dirty(dropped_dirty)
    );

endmodule

FILE: test/cache_level_checker.sv
// Cache level checker: watches all three channels, predicts each result and compares it.
module cache_level_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] address,
    input  logic        write,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        hit,
    input  logic        evicted,
    input  logic [31:0] victim_address,
    input  logic        victim_dirty,
    input  logic        dropped_dirty,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  replace_policy,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = sacl_pkg::WAYS_DEF;
    localparam int NS = sacl_pkg::SET_COUNT_DEF;
    localparam int OB = sacl_pkg::LINE_OFS_DEF;
    localparam int IB = 6;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [31:0] vaddr;
        logic        vdirty;
        logic        ddirty;
    } outcome_t;

    logic        vld   [NS][NW];
    logic        drt   [NS][NW];
    logic [19:0] tags  [NS][NW];
    logic [31:0] used  [NS][NW];
    logic [31:0] born  [NS][NW];
    logic [15:0] uses  [NS][NW];
    logic [31:0] clock_now;
    sacl_pkg::policy_t policy;
    outcome_t    outcome_q[$];

    assign pending = outcome_q.size();

    function automatic outcome_t apply_access(sacl_pkg::kind_t k, logic [31:0] a, logic wr);
        outcome_t o;
        int s;
        logic [19:0] t;
        int w;
        int vic;
        logic [31:0] key;
        logic [31:0] best;
        o = '0;
        s = a[OB +: IB];
        t = a[31 -: 20];
        w = -1;
        if (k == sacl_pkg::KIND_LOOKUP || k == sacl_pkg::KIND_INVAL)
            for (int i = NW - 1; i >= 0; i--)
                if (vld[s][i] && tags[s][i] == t) w = i;
        case (k)
            sacl_pkg::KIND_LOOKUP:
            begin
                if (clock_now != 32'hFFFF_FFFF) clock_now++;
                if (w >= 0)
                begin
                    o.hit = 1;
                    used[s][w] = clock_now;
                    if (uses[s][w] != 16'hFFFF) uses[s][w]++;
                    if (wr) drt[s][w] = 1;
                end
            end
            sacl_pkg::KIND_FILL:
            begin
                vic = -1;
                best = '0;
                for (int i = 0; i < NW; i++)
                begin
                    if (!vld[s][i])
                    begin
                        vic = i;
                        break;
                    end
                    key = (policy == sacl_pkg::POL_LRU) ? used[s][i] :
                          (policy == sacl_pkg::POL_FIFO) ? born[s][i] : {16'd0, uses[s][i]};
                    if (i == 0 || key < best)
                    begin
                        best = key;
                        vic = i;
                    end
                end
                if (vld[s][vic])
                begin
                    o.evicted = 1;
                    o.vaddr = {tags[s][vic], s[IB-1:0], {OB{1'b0}}};
                    o.vdirty = drt[s][vic];
                end
                vld[s][vic] = 1;
                drt[s][vic] = wr;
                tags[s][vic] = t;
                used[s][vic] = clock_now;
                born[s][vic] = clock_now;
                uses[s][vic] = 1;
            end
            sacl_pkg::KIND_INVAL:
                if (w >= 0)
                begin
                    o.ddirty = drt[s][w];
                    vld[s][w] = 0;
                end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                for (int w = 0; w < NW; w++)
                begin
                    vld[s][w] = 0;
                    drt[s][w] = 0;
                end
            clock_now = 0;
            policy = sacl_pkg::POL_LRU;
            outcome_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) policy = sacl_pkg::policy_t'(replace_policy);
            if (out_valid && !out_stall)
            begin
                got = '{hit, evicted, victim_address, victim_dirty, dropped_dirty};
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: hit %b/%b ev %b/%b va %h/%h vd %b/%b dd %b/%b",
                                     want.hit, got.hit, want.evicted, got.evicted,
                                     want.vaddr, got.vaddr, want.vdirty, got.vdirty,
                                     want.ddirty, got.ddirty);
                    end
                end
            end
            if (in_valid && !in_stall)
                outcome_q.push_back(apply_access(sacl_pkg::kind_t'(kind), address, write));
        end
    end
endmodule

FILE: test/testbench.sv
// Top of the cache level testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = sacl_pkg::KIND_LOOKUP;
    logic [31:0] address = '0;
    logic        write = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        hit, evicted, victim_dirty, dropped_dirty;
    logic [31:0] victim_address;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  replace_policy = sacl_pkg::POL_LRU;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          calm = 0;
    bit          hold_out = 0;
    logic [31:0] hot[16];

    set_assoc_cache_level_unit uut (.*);
    cache_level_checker chk (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall bursts, or a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_out)
            begin
                out_stall <= 1;
                repeat (60) @(posedge clk);
                hold_out = 0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_stall <= 0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send(logic [1:0] k, logic [31:0] a, logic wr);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        address <= a;
        write <= wr;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_policy(sacl_pkg::policy_t p);
        settle();
        cfg_valid <= 1;
        replace_policy <= p;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // lines sharing set s: tag varies, index fixed
    function automatic logic [31:0] in_set(int s, int t);
        return {t[19:0], s[5:0], 6'($urandom)};
    endfunction

    initial
    begin
        int s;
        int t;
        logic [1:0] k;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed
        send(sacl_pkg::KIND_LOOKUP, 32'h0, 0);
        send(sacl_pkg::KIND_INVAL, 32'hFFFF_FFFF, 1);
        send(sacl_pkg::KIND_NOP, 32'hFFFF_FFFF, 1);
        for (int i = 0; i < 5; i++) send(sacl_pkg::KIND_FILL, in_set(63, 20'hFFFFF - i), i[0]);
        send(sacl_pkg::KIND_LOOKUP, in_set(63, 20'hFFFFF), 1);
        send(sacl_pkg::KIND_LOOKUP, in_set(63, 20'hFFFFD), 0);
        send(sacl_pkg::KIND_FILL, 32'h0, 1);
        send(sacl_pkg::KIND_FILL, 32'h0, 0);
        send(sacl_pkg::KIND_LOOKUP, 32'h0, 1);
        send(sacl_pkg::KIND_INVAL, 32'h0, 0);
        send(sacl_pkg::KIND_INVAL, in_set(63, 20'hFFFFD), 0);
        send(sacl_pkg::KIND_FILL, in_set(63, 7), 1);
        send(sacl_pkg::KIND_INVAL, 32'h0, 1);
        send(sacl_pkg::KIND_INVAL, 32'h0, 0);
        // long receiver hold-off while items keep coming
        hold_out = 1;
        for (int i = 0; i < 12; i++) send(sacl_pkg::KIND_LOOKUP, 32'hFFFF_FFC0, 0);
        settle();
        for (int i = 0; i < 16; i++) hot[i] = $urandom;
        for (int ph = 0; ph < 6; ph++)
        begin
            apply_policy(sacl_pkg::policy_t'((ph == 5) ? 3 : ph % 3));
            if (ph == 5) calm = 1;
            for (int n = 0; n < 150; n++)
            begin
                // narrow set and tag pool so sets fill and evict
                s = $urandom_range(0, 3);
                t = $urandom_range(0, 7);
                if ($urandom_range(0, 15) == 0) t = $urandom;
                k = $urandom_range(0, 9) < 6 ? sacl_pkg::KIND_LOOKUP :
                    ($urandom_range(0, 2) == 0 ? sacl_pkg::KIND_INVAL : sacl_pkg::KIND_FILL);
                if ($urandom_range(0, 3) == 0) k = sacl_pkg::KIND_FILL;
                if ($urandom_range(0, 30) == 0) k = sacl_pkg::KIND_NOP;
                if ($urandom_range(0, 20) == 0)
                    send(k, $urandom, $urandom_range(0, 1));
                else if ($urandom_range(0, 20) == 0)
                    send(k, hot[$urandom_range(0, 15)], $urandom_range(0, 1));
                else
                    send(k, in_set(s, {t[19:3], t[2:0]} ^ {17'h1_5A5A ^ 17'(ph), 3'b0}),
                         $urandom_range(0, 1));
            end
        end
        settle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/sacl_front.sv
hw/rtl/sacl_back.sv
hw/rtl/set_assoc_cache_level_unit.sv
test/cache_level_checker.sv
test/testbench.sv
